// ===== design/offload_bundle_size_parser_defines.svh =====
// assertion macros shared by the bundle size parser modules
// each macro checks on the rising edge of clk and is quiet while rst is high
`ifndef OFFLOAD_BUNDLE_SIZE_PARSER_DEFINES_SVH
`define OFFLOAD_BUNDLE_SIZE_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define OBSP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("obsp same-cycle check failed");

// next-cycle implication
`define OBSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("obsp next-cycle check failed");

`else

`define OBSP_ASSERT_IMP(label, ante, cons)
`define OBSP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/obsp_pkg.sv =====
package obsp_pkg;

  // parser phases
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_MAGIC   = 4'd1,
    PH_CVER    = 4'd2,
    PH_CMETH   = 4'd3,
    PH_CSIZE   = 4'd4,
    PH_UCOUNT  = 4'd5,
    PH_UOFF    = 4'd6,
    PH_USIZE   = 4'd7,
    PH_UIDLEN  = 4'd8,
    PH_UIDSKIP = 4'd9
  } phase_t;

  // result status codes
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_BAD_MAGIC   = 2'd1;
  localparam logic [1:0] STATUS_BAD_VERSION = 2'd2;

  // field and magic lengths in bytes
  localparam logic [4:0] CMP_MAGIC_LEN = 5'd4;
  localparam logic [4:0] UNC_MAGIC_LEN = 5'd24;
  localparam logic [4:0] SHORT_FIELD_LEN = 5'd2;
  localparam logic [4:0] SIZE32_FIELD_LEN = 5'd4;
  localparam logic [4:0] WORD_FIELD_LEN = 5'd8;

  // compressed format versions
  localparam logic [15:0] VER_2 = 16'd2;
  localparam logic [15:0] VER_3 = 16'd3;

  // size of an uncompressed bundle with no entries
  localparam logic [63:0] EMPTY_BUNDLE_SIZE = 64'd32;

  // magic match mask with both candidates live: bit 0 compressed, bit 1 uncompressed
  localparam logic [1:0] CAND_BOTH = 2'b11;

  typedef struct packed {
    logic       start_of_image;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] total_size;
    logic        is_compressed;
    logic [1:0]  format_status;
  } result_t;

  // compressed magic "CCOB"
  function automatic logic [7:0] cmp_magic_byte(input logic [1:0] idx);
    logic [7:0] val;
    unique case (idx)
      2'd0:    val = 8'h43;
      2'd1:    val = 8'h43;
      2'd2:    val = 8'h4F;
      2'd3:    val = 8'h42;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // uncompressed bundle magic, 24 bytes
  function automatic logic [7:0] unc_magic_byte(input logic [4:0] idx);
    logic [7:0] val;
    unique case (idx)
      5'd0:    val = 8'h5F;
      5'd1:    val = 8'h5F;
      5'd2:    val = 8'h43;
      5'd3:    val = 8'h4C;
      5'd4:    val = 8'h41;
      5'd5:    val = 8'h4E;
      5'd6:    val = 8'h47;
      5'd7:    val = 8'h5F;
      5'd8:    val = 8'h4F;
      5'd9:    val = 8'h46;
      5'd10:   val = 8'h46;
      5'd11:   val = 8'h4C;
      5'd12:   val = 8'h4F;
      5'd13:   val = 8'h41;
      5'd14:   val = 8'h44;
      5'd15:   val = 8'h5F;
      5'd16:   val = 8'h42;
      5'd17:   val = 8'h55;
      5'd18:   val = 8'h4E;
      5'd19:   val = 8'h44;
      5'd20:   val = 8'h4C;
      5'd21:   val = 8'h45;
      5'd22:   val = 8'h5F;
      5'd23:   val = 8'h5F;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ===== design/obsp_in_reg.sv =====
module obsp_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  obsp_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output obsp_pkg::in_item_t out_item
);

  logic               valid;
  obsp_pkg::in_item_t item;

  // take a new byte whenever the held one leaves or the slot is empty
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // byte payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== design/obsp_parser.sv =====
`include "offload_bundle_size_parser_defines.svh"

module obsp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  obsp_pkg::in_item_t in_item,
  output logic               res_valid,
  input  logic               res_ready,
  output obsp_pkg::result_t  res
);

  // parser state
  obsp_pkg::phase_t parse_phase, parse_phase_next;
  logic [4:0]       byte_index, byte_index_next;
  logic [1:0]       magic_candidates, magic_candidates_next;
  logic [63:0]      field_accumulator, field_accumulator_next;
  logic [63:0]      entries_left, entries_left_next;
  logic [63:0]      held_offset, held_offset_next;
  logic [63:0]      furthest_end, furthest_end_next;
  logic [63:0]      id_bytes_left, id_bytes_left_next;
  logic [15:0]      format_version, format_version_next;

  // per-byte decode
  logic             consume;
  logic             emit;
  logic [7:0]       data;
  obsp_pkg::phase_t eff_phase;
  logic [4:0]       eff_index;
  logic [1:0]       eff_cand;
  logic [63:0]      eff_acc;
  logic [63:0]      acc_new;
  logic [4:0]       index_inc;
  logic [4:0]       field_len;
  logic             field_done;
  logic             cmp_ok;
  logic             unc_ok;
  logic [1:0]       cand_new;
  logic [15:0]      ver_new;
  logic             ver_ok;
  logic [63:0]      end_sum;
  logic             end_grows;
  logic [63:0]      entries_dec;
  logic             last_entry;
  logic [63:0]      id_dec;

  // a byte is taken only when the result register can hold whatever it causes
  assign in_ready = res_ready;
  assign consume  = in_valid && res_ready;
  assign data     = in_item.data_byte;

  // a start flag restarts the image on this very byte
  always_comb begin
    eff_phase   = in_item.start_of_image ? obsp_pkg::PH_MAGIC : parse_phase;
    eff_index   = in_item.start_of_image ? 5'd0 : byte_index;
    eff_cand    = in_item.start_of_image ? obsp_pkg::CAND_BOTH : magic_candidates;
    eff_acc     = in_item.start_of_image ? 64'd0 : field_accumulator;
  end

  // little-endian field assembly and shared compares
  always_comb begin
    acc_new   = eff_acc | ({56'd0, data} << {eff_index[2:0], 3'b000});
    index_inc = eff_index + 5'd1;
    unique case (eff_phase)
      obsp_pkg::PH_CVER, obsp_pkg::PH_CMETH: field_len = obsp_pkg::SHORT_FIELD_LEN;
      obsp_pkg::PH_CSIZE: field_len = (format_version == obsp_pkg::VER_2) ?
                                      obsp_pkg::SIZE32_FIELD_LEN : obsp_pkg::WORD_FIELD_LEN;
      default: field_len = obsp_pkg::WORD_FIELD_LEN;
    endcase
    field_done  = index_inc >= field_len;
    cmp_ok      = (eff_index < obsp_pkg::CMP_MAGIC_LEN) &&
                  (data == obsp_pkg::cmp_magic_byte(eff_index[1:0]));
    unc_ok      = (eff_index < obsp_pkg::UNC_MAGIC_LEN) &&
                  (data == obsp_pkg::unc_magic_byte(eff_index));
    cand_new    = eff_cand & {unc_ok, cmp_ok};
    ver_new     = acc_new[15:0];
    ver_ok      = (ver_new == obsp_pkg::VER_2) || (ver_new == obsp_pkg::VER_3);
    end_sum     = held_offset + acc_new;
    end_grows   = end_sum > furthest_end;
    entries_dec = entries_left - 64'd1;
    last_entry  = entries_dec == 64'd0;
    id_dec      = id_bytes_left - 64'd1;
  end

  // next phase
  always_comb begin
    parse_phase_next = parse_phase;
    if (consume) begin
      unique case (eff_phase)
        obsp_pkg::PH_IDLE: parse_phase_next = obsp_pkg::PH_IDLE;
        obsp_pkg::PH_MAGIC: begin
          if (cand_new == 2'b00) begin
            parse_phase_next = obsp_pkg::PH_IDLE;
          end else if (cand_new[0] && eff_index == obsp_pkg::CMP_MAGIC_LEN - 5'd1) begin
            parse_phase_next = obsp_pkg::PH_CVER;
          end else if (cand_new[1] && eff_index == obsp_pkg::UNC_MAGIC_LEN - 5'd1) begin
            parse_phase_next = obsp_pkg::PH_UCOUNT;
          end else begin
            parse_phase_next = obsp_pkg::PH_MAGIC;
          end
        end
        obsp_pkg::PH_CVER: begin
          if (field_done) begin
            parse_phase_next = ver_ok ? obsp_pkg::PH_CMETH : obsp_pkg::PH_IDLE;
          end else begin
            parse_phase_next = obsp_pkg::PH_CVER;
          end
        end
        obsp_pkg::PH_CMETH: begin
          parse_phase_next = field_done ? obsp_pkg::PH_CSIZE : obsp_pkg::PH_CMETH;
        end
        obsp_pkg::PH_CSIZE: begin
          parse_phase_next = field_done ? obsp_pkg::PH_IDLE : obsp_pkg::PH_CSIZE;
        end
        obsp_pkg::PH_UCOUNT: begin
          if (field_done) begin
            parse_phase_next = (acc_new == 64'd0) ? obsp_pkg::PH_IDLE : obsp_pkg::PH_UOFF;
          end else begin
            parse_phase_next = obsp_pkg::PH_UCOUNT;
          end
        end
        obsp_pkg::PH_UOFF: begin
          parse_phase_next = field_done ? obsp_pkg::PH_USIZE : obsp_pkg::PH_UOFF;
        end
        obsp_pkg::PH_USIZE: begin
          parse_phase_next = field_done ? obsp_pkg::PH_UIDLEN : obsp_pkg::PH_USIZE;
        end
        obsp_pkg::PH_UIDLEN: begin
          if (!field_done) begin
            parse_phase_next = obsp_pkg::PH_UIDLEN;
          end else if (last_entry) begin
            parse_phase_next = obsp_pkg::PH_IDLE;
          end else if (acc_new == 64'd0) begin
            parse_phase_next = obsp_pkg::PH_UOFF;
          end else begin
            parse_phase_next = obsp_pkg::PH_UIDSKIP;
          end
        end
        obsp_pkg::PH_UIDSKIP: begin
          parse_phase_next = (id_dec == 64'd0) ? obsp_pkg::PH_UOFF : obsp_pkg::PH_UIDSKIP;
        end
        default: parse_phase_next = obsp_pkg::PH_IDLE;
      endcase
    end
  end

  // datapath updates and result
  always_comb begin
    byte_index_next        = byte_index;
    magic_candidates_next  = magic_candidates;
    field_accumulator_next = field_accumulator;
    entries_left_next      = entries_left;
    held_offset_next       = held_offset;
    furthest_end_next      = furthest_end;
    id_bytes_left_next     = id_bytes_left;
    format_version_next    = format_version;
    emit                   = 1'b0;
    res                    = '0;
    if (consume) begin
      // image restart clears the field registers
      if (in_item.start_of_image) begin
        entries_left_next   = 64'd0;
        held_offset_next    = 64'd0;
        furthest_end_next   = 64'd0;
        id_bytes_left_next  = 64'd0;
        format_version_next = 16'd0;
      end
      byte_index_next        = 5'd0;
      magic_candidates_next  = eff_cand;
      field_accumulator_next = 64'd0;
      unique case (eff_phase)
        obsp_pkg::PH_IDLE: begin
          byte_index_next        = byte_index;
          field_accumulator_next = field_accumulator;
        end
        obsp_pkg::PH_MAGIC: begin
          magic_candidates_next = cand_new;
          if (cand_new == 2'b00) begin
            emit              = 1'b1;
            res.format_status = obsp_pkg::STATUS_BAD_MAGIC;
          end else if (!(cand_new[0] && eff_index == obsp_pkg::CMP_MAGIC_LEN - 5'd1) &&
                       !(cand_new[1] && eff_index == obsp_pkg::UNC_MAGIC_LEN - 5'd1)) begin
            byte_index_next = index_inc;
          end
        end
        obsp_pkg::PH_CVER: begin
          if (field_done) begin
            format_version_next = ver_new;
            if (!ver_ok) begin
              emit              = 1'b1;
              res.is_compressed = 1'b1;
              res.format_status = obsp_pkg::STATUS_BAD_VERSION;
            end
          end else begin
            byte_index_next        = index_inc;
            field_accumulator_next = acc_new;
          end
        end
        obsp_pkg::PH_CMETH: begin
          if (!field_done) begin
            byte_index_next        = index_inc;
            field_accumulator_next = acc_new;
          end
        end
        obsp_pkg::PH_CSIZE: begin
          if (field_done) begin
            emit              = 1'b1;
            res.total_size    = acc_new;
            res.is_compressed = 1'b1;
            res.format_status = obsp_pkg::STATUS_OK;
          end else begin
            byte_index_next        = index_inc;
            field_accumulator_next = acc_new;
          end
        end
        obsp_pkg::PH_UCOUNT: begin
          if (field_done) begin
            if (acc_new == 64'd0) begin
              emit           = 1'b1;
              res.total_size = obsp_pkg::EMPTY_BUNDLE_SIZE;
            end else begin
              entries_left_next = acc_new;
              furthest_end_next = 64'd0;
            end
          end else begin
            byte_index_next        = index_inc;
            field_accumulator_next = acc_new;
          end
        end
        obsp_pkg::PH_UOFF: begin
          if (field_done) begin
            held_offset_next = acc_new;
          end else begin
            byte_index_next        = index_inc;
            field_accumulator_next = acc_new;
          end
        end
        obsp_pkg::PH_USIZE: begin
          if (field_done) begin
            if (end_grows) begin
              furthest_end_next = end_sum;
            end
          end else begin
            byte_index_next        = index_inc;
            field_accumulator_next = acc_new;
          end
        end
        obsp_pkg::PH_UIDLEN: begin
          if (field_done) begin
            entries_left_next = entries_dec;
            if (last_entry) begin
              emit           = 1'b1;
              res.total_size = furthest_end;
            end else begin
              id_bytes_left_next = acc_new;
            end
          end else begin
            byte_index_next        = index_inc;
            field_accumulator_next = acc_new;
          end
        end
        obsp_pkg::PH_UIDSKIP: begin
          id_bytes_left_next = id_dec;
        end
        default: begin
          byte_index_next = 5'd0;
        end
      endcase
    end
  end

  assign res_valid = consume && emit;

  // phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= obsp_pkg::PH_IDLE;
    end else begin
      parse_phase <= parse_phase_next;
    end
  end

  // field registers, reloaded at every image start
  always_ff @(posedge clk) begin
    byte_index        <= byte_index_next;
    magic_candidates  <= magic_candidates_next;
    field_accumulator <= field_accumulator_next;
    entries_left      <= entries_left_next;
    held_offset       <= held_offset_next;
    furthest_end      <= furthest_end_next;
    id_bytes_left     <= id_bytes_left_next;
    format_version    <= format_version_next;
  end

  // a result always closes the image
  `OBSP_ASSERT_NEXT(a_emit_goes_idle, res_valid, parse_phase == obsp_pkg::PH_IDLE)
  // no result from an idle parser without a start flag
  `OBSP_ASSERT_IMP(a_idle_silent, consume && parse_phase == obsp_pkg::PH_IDLE && !in_item.start_of_image, !res_valid)
  // the magic position never runs past the longer magic
  `OBSP_ASSERT_IMP(a_magic_index, parse_phase == obsp_pkg::PH_MAGIC, byte_index < obsp_pkg::UNC_MAGIC_LEN)

endmodule

// ===== design/obsp_out_reg.sv =====
`include "offload_bundle_size_parser_defines.svh"

module obsp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  obsp_pkg::result_t in_res,
  output logic              out_valid,
  input  logic              out_ready,
  output obsp_pkg::result_t out_res
);

  logic              valid;
  obsp_pkg::result_t res;

  // slot frees when empty or when the receiver takes the held result
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_res   = res;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res <= in_res;
    end
  end

  // a failed image never reports a size
  `OBSP_ASSERT_IMP(a_fail_zero_size, valid && res.format_status != obsp_pkg::STATUS_OK, res.total_size == 64'd0)
  // a compressed result never carries the unknown magic status
  `OBSP_ASSERT_IMP(a_comp_status, valid && res.is_compressed, res.format_status != obsp_pkg::STATUS_BAD_MAGIC)

endmodule

// ===== design/offload_bundle_size_parser.sv =====
// Bundle image size parser.
// Input stream: one image byte per request. s_axis_tdata carries the byte and
// s_axis_tuser is the start flag that marks byte 0 of a new image; the flag
// restarts parsing and drops any unfinished image without a result.
// Output stream: one request per recognized or rejected image. m_axis_tdata
// carries the total size in bytes, m_axis_tuser the compressed flag (bit 0)
// and the format status (bits 2:1: ok, unknown magic, unsupported version).
// Bytes after an image's result and before the next start flag are dropped.
// Throughput: one byte per cycle unless a held result stalls the parser, set by the
// single byte-wide parse stage whose longest path is the 64-bit offset+size add and compare.
// The byte that completes an image passes the input register and the parser, and
// its result is offered from the result register.
// When the receiver stalls, the result register holds its request and the
// parser takes no byte while that slot is occupied, whether or not the byte
// would complete an image; the input register takes one more byte and then
// s_axis_tready drops until the receiver takes the result.
// Reset: both stream registers empty, parser waits for a start flag.
module offload_bundle_size_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] start_of_image
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // [63:0] total_size
  output logic [2:0]  m_axis_tuser   // [0] is_compressed, [2:1] format_status
);

  obsp_pkg::in_item_t s_item;
  obsp_pkg::in_item_t item;
  logic               item_valid;
  logic               item_ready;
  obsp_pkg::result_t  res;
  logic               res_valid;
  logic               res_ready;
  obsp_pkg::result_t  m_res;

  // pack input request
  assign s_item.start_of_image = s_axis_tuser;
  assign s_item.data_byte      = s_axis_tdata;

  // input register
  obsp_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (s_item),
    .out_valid (item_valid),
    .out_ready (item_ready),
    .out_item  (item)
  );

  // byte parser
  obsp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (item_ready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // result register
  obsp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_res    (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (m_res)
  );

  // unpack output request
  assign m_axis_tdata = m_res.total_size;
  assign m_axis_tuser = {m_res.format_status, m_res.is_compressed};

endmodule

// ===== tb/offload_bundle_size_parser_test.sv =====
`timescale 1ns / 100ps

module offload_bundle_size_parser_test;

  // image signatures, byte 0 first
  localparam logic [0:3][7:0] CCOB_SIG = {8'h43, 8'h43, 8'h4F, 8'h42};
  localparam logic [0:23][7:0] BUNDLE_SIG = {
    8'h5F, 8'h5F, 8'h43, 8'h4C, 8'h41, 8'h4E, 8'h47, 8'h5F,
    8'h4F, 8'h46, 8'h46, 8'h4C, 8'h4F, 8'h41, 8'h44, 8'h5F,
    8'h42, 8'h55, 8'h4E, 8'h44, 8'h4C, 8'h45, 8'h5F, 8'h5F
  };

  // byte-level parser mirror and queue of sizes still owed by the block
  class size_scoreboard;
    obsp_pkg::phase_t  phase;
    logic [4:0]        idx;
    logic [1:0]        cand;
    logic [63:0]       acc;
    logic [63:0]       entries;
    logic [63:0]       offs;
    logic [63:0]       far_end;
    logic [63:0]       id_left;
    logic [15:0]       ver;
    obsp_pkg::result_t sizes_due[$];
    int                failures;
    int                results_made;

    function new();
      restart();
      phase = obsp_pkg::PH_IDLE;
      failures = 0;
      results_made = 0;
    endfunction

    function void restart();
      phase = obsp_pkg::PH_MAGIC;
      idx = '0;
      cand = obsp_pkg::CAND_BOTH;
      acc = '0;
      entries = '0;
      offs = '0;
      far_end = '0;
      id_left = '0;
      ver = '0;
    endfunction

    // little-endian field collect, true once len bytes are in
    function bit take_byte(logic [7:0] b, logic [4:0] len);
      acc |= {56'd0, b} << (8 * idx[2:0]);
      idx = idx + 5'd1;
      return idx >= len;
    endfunction

    function void next_field(obsp_pkg::phase_t p);
      phase = p;
      idx = '0;
      acc = '0;
    endfunction

    function void finish_image(logic [63:0] sz, logic comp, logic [1:0] st);
      obsp_pkg::result_t r;
      r.total_size = sz;
      r.is_compressed = comp;
      r.format_status = st;
      sizes_due.insert(sizes_due.size(), r);
      results_made++;
      phase = obsp_pkg::PH_IDLE;
      idx = '0;
    endfunction

    function void take_request_byte(logic st, logic [7:0] b);
      logic [63:0] span_end;
      if (st) restart();
      case (phase)
        obsp_pkg::PH_MAGIC: begin
          if (!(idx < obsp_pkg::CMP_MAGIC_LEN && b == CCOB_SIG[idx[1:0]])) cand[0] = 1'b0;
          if (idx < obsp_pkg::UNC_MAGIC_LEN) begin
            if (b != BUNDLE_SIG[idx]) cand[1] = 1'b0;
          end else begin
            cand[1] = 1'b0;
          end
          if (cand == 2'b00) begin
            finish_image('0, 1'b0, obsp_pkg::STATUS_BAD_MAGIC);
          end else if (cand[0] && idx == obsp_pkg::CMP_MAGIC_LEN - 5'd1) begin
            next_field(obsp_pkg::PH_CVER);
          end else if (cand[1] && idx == obsp_pkg::UNC_MAGIC_LEN - 5'd1) begin
            next_field(obsp_pkg::PH_UCOUNT);
          end else begin
            idx = idx + 5'd1;
          end
        end
        obsp_pkg::PH_CVER: begin
          if (take_byte(b, obsp_pkg::SHORT_FIELD_LEN)) begin
            ver = acc[15:0];
            if (ver != obsp_pkg::VER_2 && ver != obsp_pkg::VER_3)
              finish_image('0, 1'b1, obsp_pkg::STATUS_BAD_VERSION);
            else
              next_field(obsp_pkg::PH_CMETH);
          end
        end
        obsp_pkg::PH_CMETH: begin
          if (take_byte(b, obsp_pkg::SHORT_FIELD_LEN)) next_field(obsp_pkg::PH_CSIZE);
        end
        obsp_pkg::PH_CSIZE: begin
          if (take_byte(b, (ver == obsp_pkg::VER_2) ? obsp_pkg::SIZE32_FIELD_LEN :
                                                      obsp_pkg::WORD_FIELD_LEN))
            finish_image(acc, 1'b1, obsp_pkg::STATUS_OK);
        end
        obsp_pkg::PH_UCOUNT: begin
          if (take_byte(b, obsp_pkg::WORD_FIELD_LEN)) begin
            if (acc == '0) begin
              finish_image(obsp_pkg::EMPTY_BUNDLE_SIZE, 1'b0, obsp_pkg::STATUS_OK);
            end else begin
              entries = acc;
              far_end = '0;
              next_field(obsp_pkg::PH_UOFF);
            end
          end
        end
        obsp_pkg::PH_UOFF: begin
          if (take_byte(b, obsp_pkg::WORD_FIELD_LEN)) begin
            offs = acc;
            next_field(obsp_pkg::PH_USIZE);
          end
        end
        obsp_pkg::PH_USIZE: begin
          if (take_byte(b, obsp_pkg::WORD_FIELD_LEN)) begin
            span_end = offs + acc;
            if (span_end > far_end) far_end = span_end;
            next_field(obsp_pkg::PH_UIDLEN);
          end
        end
        obsp_pkg::PH_UIDLEN: begin
          if (take_byte(b, obsp_pkg::WORD_FIELD_LEN)) begin
            entries = entries - 64'd1;
            if (entries == '0) begin
              finish_image(far_end, 1'b0, obsp_pkg::STATUS_OK);
            end else begin
              id_left = acc;
              next_field((id_left == '0) ? obsp_pkg::PH_UOFF : obsp_pkg::PH_UIDSKIP);
            end
          end
        end
        obsp_pkg::PH_UIDSKIP: begin
          id_left = id_left - 64'd1;
          if (id_left == '0) next_field(obsp_pkg::PH_UOFF);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_size_result(logic [63:0] size_got, logic comp_got,
                                    logic [1:0] status_got);
      obsp_pkg::result_t want;
      if (sizes_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: size %h compressed %b status %0d",
                   size_got, comp_got, status_got);
        return;
      end
      want = sizes_due.pop_front();
      if (want.total_size !== size_got || want.is_compressed !== comp_got ||
          want.format_status !== status_got) begin
        failures++;
        if (failures <= 10)
          $display("result mismatch: expected size %h compressed %b status %0d, %s",
                   want.total_size, want.is_compressed, want.format_status,
                   $sformatf("got size %h compressed %b status %0d",
                             size_got, comp_got, status_got));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  size_scoreboard board;
  int bytes_sent = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int rx_wait = 0;
  int hold_req = 0;

  offload_bundle_size_parser uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // result side: random stalls per request, long hold-off on demand
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        board.check_size_result(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[2:1]);
        if ($urandom_range(0, 7) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 9);
      end
      if (hold_req > 0) begin
        rx_wait = hold_req;
        hold_req = 0;
      end
      m_axis_tready <= (rx_wait == 0);
      if (rx_wait > 0) rx_wait--;
    end
  end

  // one byte request, returns at the edge that accepts it with tvalid still high
  task automatic send_byte(input logic st, input logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= st;
    do @(posedge clk); while (!s_axis_tready);
    board.take_request_byte(st, b);
    bytes_sent++;
  endtask

  task automatic send_field(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) send_byte(1'b0, v[8*i +: 8]);
  endtask

  task automatic send_junk(input int n);
    repeat (n) send_byte(1'b0, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_ccob_magic();
    for (int i = 0; i < 4; i++) send_byte(i == 0, CCOB_SIG[i]);
  endtask

  // compressed image, size field only for supported versions
  task automatic send_cmp(input logic [15:0] v, input logic [63:0] sz);
    send_ccob_magic();
    send_field({48'd0, v}, 2);
    send_field({$urandom, $urandom}, 2);
    if (v == obsp_pkg::VER_2) send_field(sz, 4);
    else if (v == obsp_pkg::VER_3) send_field(sz, 8);
  endtask

  task automatic send_unc_head(input logic [63:0] count);
    for (int i = 0; i < 24; i++) send_byte(i == 0, BUNDLE_SIG[i]);
    send_field(count, 8);
  endtask

  task automatic send_entry(input logic [63:0] off, input logic [63:0] sz,
                            input logic [63:0] idlen, input int ids_sent);
    send_field(off, 8);
    send_field(sz, 8);
    send_field(idlen, 8);
    send_junk(ids_sent);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (board.sizes_due.size() != 0);
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 3))
      0: return 64'($urandom_range(0, 255));
      1: return 64'($urandom_range(0, 65535));
      2: return {$urandom, $urandom};
      default: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int pick;
    int k;
    int n;
    bit use_unc;
    logic [63:0] idl;

    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: bytes before any start are dropped
    send_junk(3);
    // compressed sizes at the extremes
    send_cmp(obsp_pkg::VER_2, 64'hFFFF_FFFF);
    send_cmp(obsp_pkg::VER_3, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmp(obsp_pkg::VER_3, 64'd0);
    // unsupported versions, including one whose low byte looks right
    send_cmp(16'd1, 64'd0);
    send_cmp(16'hFFFF, 64'd0);
    send_cmp(16'h0302, 64'd0);
    // unknown magic on the first byte and on the last byte of each signature
    send_byte(1'b1, 8'h00);
    send_byte(1'b1, 8'hFF);
    for (int i = 0; i < 3; i++) send_byte(i == 0, CCOB_SIG[i]);
    send_byte(1'b0, 8'h00);
    for (int i = 0; i < 23; i++) send_byte(i == 0, BUNDLE_SIG[i]);
    send_byte(1'b0, 8'h00);
    // empty bundle
    send_unc_head(64'd0);
    // end wraps past 2^64, last id length at max and never awaited
    send_unc_head(64'd1);
    send_entry(64'hFFFF_FFFF_FFFF_FFFF, 64'd2, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    // several entries with and without ids, trailing bytes ignored
    send_unc_head(64'd3);
    send_entry(64'h100, 64'h40, 64'd3, 3);
    send_entry(64'h10, 64'h20, 64'd0, 0);
    send_entry(64'h200, 64'h8, 64'd2, 0);
    send_junk(4);
    // every entry ends at zero
    send_unc_head(64'd2);
    send_entry(64'd0, 64'd0, 64'd1, 1);
    send_entry(64'd0, 64'd0, 64'd0, 0);
    // restart in the middle of a compressed header and of an id skip
    send_ccob_magic();
    send_byte(1'b0, obsp_pkg::VER_2[7:0]);
    send_cmp(obsp_pkg::VER_2, 64'd5);
    send_unc_head(64'd2);
    send_entry(64'd1, 64'd1, 64'd6, 2);
    send_cmp(obsp_pkg::VER_3, 64'h0123_4567_89AB_CDEF);

    // receiver holds off while single-byte rejects pile up
    hold_req = 300;
    tx_calm = 1'b1;
    repeat (12) send_byte(1'b1, 8'($urandom_range(0, 8'h42)));
    wait_for_results();

    // random images, mostly well formed
    while (bytes_sent < 550) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_cmp(($urandom_range(0, 1) != 0) ? obsp_pkg::VER_3 : obsp_pkg::VER_2,
                 rand_value());
      end else if (pick < 40) begin
        send_cmp(16'($urandom), rand_value());
      end else if (pick < 70) begin
        n = $urandom_range(0, 3);
        send_unc_head(64'(n));
        for (int e = 0; e < n; e++) begin
          idl = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(1, 5));
          if (e == n - 1 && $urandom_range(0, 3) == 0) idl = rand_value();
          send_entry(rand_value(), rand_value(), idl, (e == n - 1) ? 0 : int'(idl));
        end
      end else if (pick < 85) begin
        // signature prefix then a random byte
        k = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 23) : $urandom_range(0, 3);
        use_unc = (k > 3) || ($urandom_range(0, 1) != 0);
        for (int i = 0; i < k; i++) send_byte(i == 0, use_unc ? BUNDLE_SIG[i] : CCOB_SIG[i]);
        send_byte(k == 0, 8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
        // images cut short by the next start
        case ($urandom_range(0, 2))
          0: begin
            send_ccob_magic();
            send_junk($urandom_range(0, 5));
          end
          1: begin
            send_unc_head({$urandom, $urandom});
            n = $urandom_range(0, 3);
            send_entry(rand_value(), rand_value(), 64'(n), n);
          end
          default: begin
            send_ccob_magic();
            send_field({48'd0, obsp_pkg::VER_3}, 2);
            send_field({$urandom, $urandom}, 2);
            send_field({$urandom, $urandom}, $urandom_range(0, 7));
          end
        endcase
      end else begin
        send_junk($urandom_range(1, 6));
      end
      if ($urandom_range(0, 3) == 0) send_junk($urandom_range(1, 3));
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    if (board.failures == 0 && board.sizes_due.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/obsp_pkg.sv
design/obsp_in_reg.sv
design/obsp_parser.sv
design/obsp_out_reg.sv
design/offload_bundle_size_parser.sv
tb/offload_bundle_size_parser_test.sv
